### hw/rtl/hvs_pkg.sv
// ----------------------------------------------------------------------------
// hvs_pkg: shared types and constants for the high-voltage supply command slave
// frame state layout, instruction codes, duty limits and update interval
// ----------------------------------------------------------------------------
`default_nettype none

package hvs_pkg;

  localparam int unsigned SAMPLES     = 500;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned SAMPLE_W    = 10;
  localparam int unsigned DUTY_W      = 9;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [COUNT_W-1:0] SAMPLES_LIMIT = COUNT_W'(SAMPLES);
  localparam logic [DUTY_W-1:0]  DUTY_OFF      = DUTY_W'(2);

  // instruction codes carried in the first byte of a frame
  localparam logic [BYTE_W-1:0] INS_STATUS     = 8'd1;
  localparam logic [BYTE_W-1:0] INS_STATUS_ALT = 8'd11;
  localparam logic [BYTE_W-1:0] INS_SET_BOTH   = 8'd2;
  localparam logic [BYTE_W-1:0] INS_SET_NEG    = 8'd12;
  localparam logic [BYTE_W-1:0] INS_PROBE_ID   = 8'd3;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_IDLE  = 3'd0;
  localparam logic [POS_W-1:0] POS_INSTR = 3'd1;
  localparam logic [POS_W-1:0] POS_PAD   = 3'd2;
  localparam logic [POS_W-1:0] POS_POSHV = 3'd3;
  localparam logic [POS_W-1:0] POS_NEGHV = 3'd4;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VERSION  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PROBE_ID = 1'd1;

  typedef struct packed {
    logic [POS_W-1:0]  byte_position;
    logic [BYTE_W-1:0] instruction_code;
    logic [BYTE_W-1:0] pending_reply;
    logic [BYTE_W-1:0] pos_setting;
    logic [BYTE_W-1:0] neg_setting;
  } frame_t;

endpackage

`default_nettype wire

### hw/rtl/hv_supply_command_slave_unit.sv
// ----------------------------------------------------------------------------
// hv_supply_command_slave_unit: spi command slave and pwm duty control loop
// result: a pass accepted at one edge has its result in the output register next cycle
// throughput: one pass per cycle while out_ready holds; the single result register stalls in_ready otherwise
// reset (rst, synchronous): frame state, settings and counter clear, duty registers go to off (2)
// ----------------------------------------------------------------------------
`default_nettype none

module hv_supply_command_slave_unit (
  input  logic                              clk,
  input  logic                              rst,
  // pass request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              spi_valid,
  input  logic [hvs_pkg::BYTE_W-1:0]        spi_byte,
  input  logic                              polarity_pin,
  input  logic                              interlock_a,
  input  logic                              interlock_b,
  input  logic [hvs_pkg::SAMPLE_W-1:0]      current_sample,
  // result request channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hvs_pkg::BYTE_W-1:0]        reply_byte,
  output logic                              indicator_pin,
  output logic [hvs_pkg::DUTY_W-1:0]        pos_duty,
  output logic [hvs_pkg::DUTY_W-1:0]        neg_duty,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hvs_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [hvs_pkg::BYTE_W-1:0]        cfg_data
);

  // configuration registers
  logic [hvs_pkg::BYTE_W-1:0]  version_code;
  logic [hvs_pkg::BYTE_W-1:0]  probe_id;

  // loop state
  hvs_pkg::frame_t             frame;
  hvs_pkg::frame_t             frame_next;
  hvs_pkg::frame_t             frame_byte;
  logic [hvs_pkg::BYTE_W-1:0]  current_monitor;
  logic [hvs_pkg::COUNT_W-1:0] pass_count;
  logic [hvs_pkg::COUNT_W-1:0] pass_count_next;
  logic [hvs_pkg::DUTY_W-1:0]  pos_duty_reg;
  logic [hvs_pkg::DUTY_W-1:0]  neg_duty_reg;
  logic [hvs_pkg::DUTY_W-1:0]  pos_duty_next;
  logic [hvs_pkg::DUTY_W-1:0]  neg_duty_next;

  logic in_accept;
  logic armed;
  logic duty_update;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // a new pass enters whenever the result register is free or being drained
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  assign armed = interlock_a || interlock_b;

  // byte handling, bypassed on passes without a received byte
  hvs_frame_decoder u_frame_decoder (
    .frame           (frame),
    .rx              (spi_byte),
    .current_monitor (current_monitor),
    .version_code    (version_code),
    .probe_id        (probe_id),
    .frame_next      (frame_byte)
  );

  always_comb begin
    frame_next = spi_valid ? frame_byte : frame;
    // interlocks both inactive: settings drop after byte handling
    if (!armed) begin
      frame_next.pos_setting = '0;
      frame_next.neg_setting = '0;
    end
  end

  // pass counter with wrap at the update interval
  always_comb begin
    pass_count_next = pass_count + hvs_pkg::COUNT_W'(1);
    duty_update     = (pass_count_next >= hvs_pkg::SAMPLES_LIMIT);
    if (duty_update) begin
      pass_count_next = '0;
    end
  end

  // duty recompute from the settings as they stand after this pass
  always_comb begin
    pos_duty_next = pos_duty_reg;
    neg_duty_next = neg_duty_reg;
    if (duty_update) begin
      if (frame_next.pos_setting == '0) begin
        pos_duty_next = hvs_pkg::DUTY_OFF;
      end else if (!polarity_pin) begin
        pos_duty_next = hvs_pkg::DUTY_OFF + hvs_pkg::DUTY_W'(frame_next.pos_setting);
      end
      if (frame_next.neg_setting == '0) begin
        neg_duty_next = hvs_pkg::DUTY_OFF;
      end else if (polarity_pin) begin
        neg_duty_next = hvs_pkg::DUTY_OFF + hvs_pkg::DUTY_W'(frame_next.neg_setting);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      version_code <= hvs_pkg::BYTE_W'(16);
      probe_id     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hvs_pkg::CFG_VERSION:  version_code <= cfg_data;
        hvs_pkg::CFG_PROBE_ID: probe_id     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // loop state advances once per accepted pass
  always_ff @(posedge clk) begin
    if (rst) begin
      frame           <= '0;
      current_monitor <= '0;
      pass_count      <= '0;
      pos_duty_reg    <= hvs_pkg::DUTY_OFF;
      neg_duty_reg    <= hvs_pkg::DUTY_OFF;
    end else if (in_accept) begin
      frame           <= frame_next;
      // monitor keeps the top 8 bits of the sample
      current_monitor <= current_sample[hvs_pkg::SAMPLE_W-1:2];
      pass_count      <= pass_count_next;
      pos_duty_reg    <= pos_duty_next;
      neg_duty_reg    <= neg_duty_next;
    end
  end

  // result register, holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      // reply is the byte prepared on the previous received byte
      reply_byte    <= spi_valid ? frame.pending_reply : '0;
      indicator_pin <= spi_valid ? 1'b0 : polarity_pin;
      pos_duty      <= pos_duty_next;
      neg_duty      <= neg_duty_next;
    end
  end

`ifndef ASSERT_OFF
  a_position_in_frame: assert property (@(posedge clk) disable iff (rst)
    frame.byte_position <= hvs_pkg::POS_NEGHV)
    else $error("byte position beyond frame end");

  a_count_below_limit: assert property (@(posedge clk) disable iff (rst)
    pass_count < hvs_pkg::SAMPLES_LIMIT)
    else $error("pass counter reached update interval");

  a_duty_floor: assert property (@(posedge clk) disable iff (rst)
    pos_duty_reg >= hvs_pkg::DUTY_OFF && neg_duty_reg >= hvs_pkg::DUTY_OFF)
    else $error("duty below off level");

  a_disarm_clears: assert property (@(posedge clk) disable iff (rst)
    in_accept && !interlock_a && !interlock_b |=>
      frame.pos_setting == '0 && frame.neg_setting == '0)
    else $error("settings kept with interlocks inactive");

  a_duty_only_on_update: assert property (@(posedge clk) disable iff (rst)
    in_accept && !duty_update |=> $stable(pos_duty_reg) && $stable(neg_duty_reg))
    else $error("duty changed outside an update pass");
`endif

endmodule

`default_nettype wire

### hw/rtl/hvs_frame_decoder.sv
// ----------------------------------------------------------------------------
// hvs_frame_decoder: next frame state for one received byte
// advances the byte position, latches the instruction and prepares the reply
// ----------------------------------------------------------------------------
`default_nettype none

module hvs_frame_decoder (
  input  hvs_pkg::frame_t                 frame,
  input  logic [hvs_pkg::BYTE_W-1:0]      rx,
  input  logic [hvs_pkg::BYTE_W-1:0]      current_monitor,
  input  logic [hvs_pkg::BYTE_W-1:0]      version_code,
  input  logic [hvs_pkg::BYTE_W-1:0]      probe_id,
  output hvs_pkg::frame_t                 frame_next
);

  logic [hvs_pkg::POS_W-1:0]  pos;
  logic [hvs_pkg::BYTE_W-1:0] ins;
  logic                       ins_known;

  assign pos = frame.byte_position + hvs_pkg::POS_W'(1);
  assign ins = frame.instruction_code;
  assign ins_known = (ins == hvs_pkg::INS_STATUS) || (ins == hvs_pkg::INS_STATUS_ALT) ||
                     (ins == hvs_pkg::INS_SET_BOTH) || (ins == hvs_pkg::INS_SET_NEG) ||
                     (ins == hvs_pkg::INS_PROBE_ID);

  always_comb begin
    frame_next = frame;
    frame_next.byte_position = pos;
    unique case (pos)
      hvs_pkg::POS_INSTR: begin
        frame_next.instruction_code = rx;
        if ((rx == hvs_pkg::INS_STATUS) || (rx == hvs_pkg::INS_STATUS_ALT)) begin
          frame_next.pending_reply = '0;
        end else if ((rx == hvs_pkg::INS_SET_BOTH) || (rx == hvs_pkg::INS_SET_NEG)) begin
          frame_next.pending_reply = current_monitor;
        end else if (rx == hvs_pkg::INS_PROBE_ID) begin
          frame_next.pending_reply = probe_id;
        end
      end
      hvs_pkg::POS_PAD: begin
        if (ins_known) begin
          frame_next.pending_reply = '0;
        end
      end
      hvs_pkg::POS_POSHV: begin
        frame_next.pending_reply = '0;
        if (ins == hvs_pkg::INS_SET_BOTH) begin
          frame_next.pos_setting = rx;
        end
      end
      hvs_pkg::POS_NEGHV: begin
        frame_next.byte_position = hvs_pkg::POS_IDLE;
        frame_next.pending_reply = version_code;
        if ((ins == hvs_pkg::INS_SET_BOTH) || (ins == hvs_pkg::INS_SET_NEG)) begin
          frame_next.neg_setting = rx;
        end
      end
      default: begin
        // positions past the frame end do nothing beyond advancing
      end
    endcase
  end

endmodule

`default_nettype wire
